[src/rbm_pkg.sv]
`timescale 1ns / 1ps

package rbm_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_STRIPES = 64;
	localparam int NODE_W      = 6;
	localparam int STRIPE_W    = 6;
	localparam int CNT_W       = 7;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_MARK  = 2'd1;
	localparam logic [1:0] ACT_SOLVE = 2'd2;

	localparam logic REG_NODE_COUNT   = 1'b0;
	localparam logic REG_STRIPE_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] NODE_COUNT_RESET   = 7'd64;
	localparam logic [CNT_W-1:0] STRIPE_COUNT_RESET = 7'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_ROOT,
		ST_ROW,
		ST_SCAN,
		ST_POP,
		ST_OWNER,
		ST_COMMIT_WR,
		ST_NEXT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [STRIPE_W-1:0] stripe_index;
		logic [NODE_W-1:0]   node_id;
	} cmd_t;

	typedef struct packed {
		logic [STRIPE_W-1:0] out_stripe;
		logic [NODE_W-1:0]   dest_node;
		logic                failed;
		logic                last;
	} result_t;

	// One level of the augmenting-path search.
	typedef struct packed {
		logic [STRIPE_W-1:0] stripe;
		logic [CNT_W-1:0]    next;
		logic [NODE_W-1:0]   pnode;
	} frame_t;

endpackage

[src/receiver_bipartite_matcher.sv]
`timescale 1ns / 1ps

// Receiver matcher: gives each repair stripe a distinct receiver node that holds none of its
// chunks. A word is taken when start is high and busy is low. A clear word never makes the
// block busy, and a mark word does a read, modify and write of the stripe's eligibility row.
// A solve word runs one augmenting-path search per stripe on a single node compare unit that
// tests one node per cycle while it scans a row, so its length depends on the data: it grows
// with each node tested, each scan that runs off the end of its row, each eligibility row
// loaded for a search level entered or resumed, each level of a found path whose matching is
// rewritten and each move on to the next stripe. It then sends the lesser of stripe_count and
// 64 results on consecutive cycles, or one failed result; the last result appears in the
// first cycle in which busy is low again. The receiver cannot stall: every result is on the
// result port for exactly one cycle while strobe is high and must be taken then.

module receiver_bipartite_matcher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rbm_pkg::cmd_t        cmd,
	output logic                 busy,
	output logic                 strobe,
	output rbm_pkg::result_t     result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	rbm_pkg::state_t state_q, state_d;

	logic [rbm_pkg::CNT_W-1:0] node_count_q, stripe_count_q;
	logic [rbm_pkg::CNT_W-1:0] n_lim, m_lim;

	logic [rbm_pkg::MAX_STRIPES-1:0] elig_valid_q;
	logic [rbm_pkg::MAX_NODES-1:0]   owner_valid_q;
	logic [rbm_pkg::MAX_NODES-1:0]   visited_q;
	logic [rbm_pkg::MAX_NODES-1:0]   row_q;

	logic [rbm_pkg::STRIPE_W-1:0] root_q, depth_q, cur_stripe_q, emit_idx_q;
	logic [rbm_pkg::STRIPE_W-1:0] mark_si_q;
	logic [rbm_pkg::NODE_W-1:0]   mark_ni_q;
	logic [rbm_pkg::CNT_W-1:0]    j_q;

	logic                         emit_s1, fail_s1, last_s1;
	logic [rbm_pkg::STRIPE_W-1:0] stripe_s1;

	logic accept, cfg_write, mark_in_range;
	logic scan_end, scan_hit, node_free, root_last, emit_last;
	logic [rbm_pkg::NODE_W-1:0] j_idx;

	logic                            elig_we;
	logic [rbm_pkg::STRIPE_W-1:0]    elig_waddr, elig_raddr;
	logic [rbm_pkg::MAX_NODES-1:0]   elig_wdata, elig_rdata;
	logic                            own_we;
	logic [rbm_pkg::NODE_W-1:0]      own_waddr, own_raddr;
	logic [rbm_pkg::STRIPE_W-1:0]    own_wdata, own_rdata;
	logic                            recv_we;
	logic [rbm_pkg::STRIPE_W-1:0]    recv_waddr, recv_raddr;
	logic [rbm_pkg::NODE_W-1:0]      recv_wdata, recv_rdata;
	logic                            stk_we;
	logic [rbm_pkg::STRIPE_W-1:0]    stk_waddr, stk_raddr;
	rbm_pkg::frame_t                 stk_wdata, stk_rdata;

	assign accept    = start && !busy;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	assign n_lim = (node_count_q > rbm_pkg::CNT_W'(rbm_pkg::MAX_NODES)) ?
		rbm_pkg::CNT_W'(rbm_pkg::MAX_NODES) : node_count_q;
	assign m_lim = (stripe_count_q > rbm_pkg::CNT_W'(rbm_pkg::MAX_STRIPES)) ?
		rbm_pkg::CNT_W'(rbm_pkg::MAX_STRIPES) : stripe_count_q;

	assign mark_in_range =
		({1'b0, cmd.stripe_index} < rbm_pkg::CNT_W'(rbm_pkg::MAX_STRIPES)) &&
		({1'b0, cmd.node_id} < rbm_pkg::CNT_W'(rbm_pkg::MAX_NODES));

	// The shared compare unit: one node of the current row per cycle while the row is scanned.
	assign j_idx     = j_q[rbm_pkg::NODE_W-1:0];
	assign scan_end  = (j_q >= n_lim);
	assign scan_hit  = !scan_end && row_q[j_idx] && !visited_q[j_idx];
	assign node_free = !owner_valid_q[j_idx];
	assign root_last = (({1'b0, root_q} + 7'd1) == m_lim);
	assign emit_last = (({1'b0, emit_idx_q} + 7'd1) == m_lim);

	always_comb begin
		unique case (paddr[2])
			rbm_pkg::REG_NODE_COUNT:   prdata = {25'd0, node_count_q};
			rbm_pkg::REG_STRIPE_COUNT: prdata = {25'd0, stripe_count_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbm_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd.action)
						rbm_pkg::ACT_MARK:
							state_d = mark_in_range ? rbm_pkg::ST_MARK_RD : rbm_pkg::ST_IDLE;
						rbm_pkg::ACT_SOLVE:
							state_d = (m_lim == 7'd0) ? rbm_pkg::ST_IDLE : rbm_pkg::ST_ROOT;
						default: state_d = rbm_pkg::ST_IDLE;
					endcase
				end
			end
			rbm_pkg::ST_MARK_RD: state_d = rbm_pkg::ST_MARK_WR;
			rbm_pkg::ST_MARK_WR: state_d = rbm_pkg::ST_IDLE;
			rbm_pkg::ST_ROOT:    state_d = rbm_pkg::ST_ROW;
			rbm_pkg::ST_ROW:     state_d = rbm_pkg::ST_SCAN;
			rbm_pkg::ST_SCAN: begin
				priority if (scan_end) begin
					state_d = (depth_q == '0) ? rbm_pkg::ST_IDLE : rbm_pkg::ST_POP;
				end else if (scan_hit) begin
					state_d = rbm_pkg::ST_OWNER;
				end else begin
					state_d = rbm_pkg::ST_SCAN;
				end
			end
			rbm_pkg::ST_POP: state_d = rbm_pkg::ST_ROW;
			rbm_pkg::ST_OWNER: begin
				priority if (!node_free) begin
					state_d = rbm_pkg::ST_ROW;
				end else if (depth_q == '0) begin
					state_d = rbm_pkg::ST_NEXT;
				end else begin
					state_d = rbm_pkg::ST_COMMIT_WR;
				end
			end
			rbm_pkg::ST_COMMIT_WR: begin
				if (depth_q == '0) begin
					state_d = rbm_pkg::ST_NEXT;
				end
			end
			rbm_pkg::ST_NEXT: state_d = root_last ? rbm_pkg::ST_EMIT : rbm_pkg::ST_ROOT;
			rbm_pkg::ST_EMIT: begin
				if (emit_last) begin
					state_d = rbm_pkg::ST_IDLE;
				end
			end
			default: state_d = rbm_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		busy       = (state_q != rbm_pkg::ST_IDLE);
		elig_we    = 1'b0;
		elig_waddr = mark_si_q;
		elig_wdata = (elig_valid_q[mark_si_q] ? elig_rdata : '1) &
			~(rbm_pkg::MAX_NODES'(1) << mark_ni_q);
		elig_raddr = cur_stripe_q;
		own_we     = 1'b0;
		own_waddr  = j_idx;
		own_wdata  = cur_stripe_q;
		own_raddr  = j_idx;
		recv_we    = 1'b0;
		recv_waddr = cur_stripe_q;
		recv_wdata = j_idx;
		recv_raddr = emit_idx_q;
		stk_we     = 1'b0;
		stk_waddr  = depth_q;
		stk_wdata  = '{stripe: cur_stripe_q, next: j_q + 7'd1, pnode: j_idx};
		// Pops and the path rewrite always read the level below the current one.
		stk_raddr  = depth_q - 6'd1;
		unique case (state_q)
			rbm_pkg::ST_MARK_RD: elig_raddr = mark_si_q;
			rbm_pkg::ST_MARK_WR: elig_we = 1'b1;
			rbm_pkg::ST_ROOT:    elig_raddr = root_q;
			rbm_pkg::ST_POP:     elig_raddr = stk_rdata.stripe;
			rbm_pkg::ST_OWNER: begin
				if (node_free) begin
					own_we  = 1'b1;
					recv_we = 1'b1;
				end else begin
					stk_we     = 1'b1;
					elig_raddr = own_rdata;
				end
			end
			rbm_pkg::ST_COMMIT_WR: begin
				own_we     = 1'b1;
				own_waddr  = stk_rdata.pnode;
				own_wdata  = stk_rdata.stripe;
				recv_we    = 1'b1;
				recv_waddr = stk_rdata.stripe;
				recv_wdata = stk_rdata.pnode;
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rbm_pkg::ST_IDLE;
			node_count_q   <= rbm_pkg::NODE_COUNT_RESET;
			stripe_count_q <= rbm_pkg::STRIPE_COUNT_RESET;
			elig_valid_q   <= '0;
			owner_valid_q  <= '0;
			emit_s1        <= 1'b0;
			fail_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_s1 <= (state_q == rbm_pkg::ST_EMIT);
			fail_s1 <= (state_q == rbm_pkg::ST_SCAN) && scan_end && (depth_q == '0);
			if (cfg_write) begin
				unique case (paddr[2])
					rbm_pkg::REG_NODE_COUNT:   node_count_q   <= pwdata[6:0];
					rbm_pkg::REG_STRIPE_COUNT: stripe_count_q <= pwdata[6:0];
					default: begin
					end
				endcase
			end
			if (accept && (cmd.action == rbm_pkg::ACT_CLEAR)) begin
				elig_valid_q  <= '0;
				owner_valid_q <= '0;
			end
			if (accept && (cmd.action == rbm_pkg::ACT_SOLVE)) begin
				owner_valid_q <= '0;
			end
			if (elig_we) begin
				elig_valid_q[elig_waddr] <= 1'b1;
			end
			if (own_we) begin
				owner_valid_q[own_waddr] <= 1'b1;
			end
		end
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			mark_si_q <= cmd.stripe_index;
			mark_ni_q <= cmd.node_id;
			root_q    <= '0;
		end
		unique case (state_q)
			rbm_pkg::ST_ROOT: begin
				cur_stripe_q <= root_q;
				j_q          <= '0;
				depth_q      <= '0;
				visited_q    <= '0;
			end
			rbm_pkg::ST_ROW: begin
				row_q <= elig_valid_q[cur_stripe_q] ? elig_rdata : '1;
			end
			rbm_pkg::ST_SCAN: begin
				priority if (scan_end) begin
					if (depth_q != '0) begin
						depth_q <= depth_q - 6'd1;
					end
					stripe_s1 <= root_q;
					last_s1   <= 1'b1;
				end else if (scan_hit) begin
					visited_q[j_idx] <= 1'b1;
				end else begin
					j_q <= j_q + 7'd1;
				end
			end
			rbm_pkg::ST_POP: begin
				cur_stripe_q <= stk_rdata.stripe;
				j_q          <= stk_rdata.next;
			end
			rbm_pkg::ST_OWNER: begin
				if (node_free) begin
					if (depth_q != '0) begin
						depth_q <= depth_q - 6'd1;
					end
				end else begin
					depth_q      <= depth_q + 6'd1;
					cur_stripe_q <= own_rdata;
					j_q          <= '0;
				end
			end
			rbm_pkg::ST_COMMIT_WR: begin
				if (depth_q != '0) begin
					depth_q <= depth_q - 6'd1;
				end
			end
			rbm_pkg::ST_NEXT: begin
				root_q     <= root_q + 6'd1;
				emit_idx_q <= '0;
			end
			rbm_pkg::ST_EMIT: begin
				stripe_s1  <= emit_idx_q;
				last_s1    <= emit_last;
				emit_idx_q <= emit_idx_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

	assign strobe            = emit_s1 || fail_s1;
	assign result.out_stripe = stripe_s1;
	assign result.dest_node  = fail_s1 ? '0 : recv_rdata;
	assign result.failed     = fail_s1;
	assign result.last       = last_s1;

	rbm_ram #(.WIDTH(rbm_pkg::MAX_NODES), .DEPTH(rbm_pkg::MAX_STRIPES)) u_elig_ram (
		.clk   (clk),
		.we    (elig_we),
		.waddr (elig_waddr),
		.wdata (elig_wdata),
		.raddr (elig_raddr),
		.rdata (elig_rdata)
	);

	rbm_ram #(.WIDTH(rbm_pkg::STRIPE_W), .DEPTH(rbm_pkg::MAX_NODES)) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_waddr),
		.wdata (own_wdata),
		.raddr (own_raddr),
		.rdata (own_rdata)
	);

	rbm_ram #(.WIDTH(rbm_pkg::NODE_W), .DEPTH(rbm_pkg::MAX_STRIPES)) u_recv_ram (
		.clk   (clk),
		.we    (recv_we),
		.waddr (recv_waddr),
		.wdata (recv_wdata),
		.raddr (recv_raddr),
		.rdata (recv_rdata)
	);

	rbm_ram #(.WIDTH($bits(rbm_pkg::frame_t)), .DEPTH(rbm_pkg::MAX_STRIPES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// A failed result ends its solve.
	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.failed |-> result.last)
		else $error("failed result without last");

	// Every level above the root on the search path belongs to a stripe matched earlier in this solve.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbm_pkg::ST_SCAN) |-> (depth_q <= root_q))
		else $error("search depth beyond matched stripes");

	// A clear word never makes the block busy.
	a_clear_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.action == rbm_pkg::ACT_CLEAR) |=> !busy)
		else $error("clear word left the block busy");

	// Results of a solve never mix with a failure report.
	a_no_mixed_results: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_s1 && fail_s1))
		else $error("result and failure in the same cycle");

endmodule

[src/rbm_ram.sv]
`timescale 1ns / 1ps

module rbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[dv/receiver_bipartite_matcher_test.sv]
`timescale 1ns / 1ps

module receiver_bipartite_matcher_test;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [rbm_pkg::CNT_W-1:0] NODE_FREE = 7'd64;
	localparam int CMD_W = $bits(rbm_pkg::cmd_t);
	localparam int WATCHDOG_LIMIT = 1500000;
	localparam int RANDOM_WORDS_PER_PHASE = 45;

	typedef enum logic [1:0] {ROW_WORD, ROW_NODES, ROW_STRIPES} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		rbm_pkg::cmd_t             w;
		logic [rbm_pkg::CNT_W-1:0] value;
		logic                      typed;
		rbm_pkg::result_t          res;
	} step_t;

	localparam rbm_pkg::result_t NO_RES = '0;

	logic             clk;
	logic             arst_n;
	logic             start;
	rbm_pkg::cmd_t    cmd;
	logic             busy;
	logic             strobe;
	rbm_pkg::result_t result;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	// Mirror of the block: eligibility rows, node ownership and the two registers.
	logic [rbm_pkg::MAX_NODES-1:0] elig_row [rbm_pkg::MAX_STRIPES];
	logic [rbm_pkg::CNT_W-1:0]     owner    [rbm_pkg::MAX_NODES];
	logic [rbm_pkg::CNT_W-1:0]     node_cfg;
	logic [rbm_pkg::CNT_W-1:0]     stripe_cfg;

	rbm_pkg::result_t solve_out[$];
	rbm_pkg::result_t due_results[$];
	int      mismatches;
	int      idle_pct;
	int      words_left;
	int      quiet_cycles;

	step_t plan [27] = '{
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b1, {6'd0, 6'd0, 1'b0, 1'b1}},
		'{ROW_WORD, {rbm_pkg::ACT_MARK, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b1, {6'd0, 6'd1, 1'b0, 1'b1}},
		'{ROW_WORD, {rbm_pkg::ACT_MARK, 6'd0, 6'd63}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_MARK, 6'd63, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {ACT_UNUSED, 6'd63, 6'd63}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd63, 6'd63}, 7'd0, 1'b1, {6'd0, 6'd1, 1'b0, 1'b1}},
		'{ROW_NODES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b1, {6'd0, 6'd0, 1'b1, 1'b1}},
		'{ROW_NODES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd127, 1'b0, NO_RES},
		'{ROW_STRIPES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd64, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_CLEAR, 6'd63, 6'd63}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_NODES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd2, 1'b0, NO_RES},
		'{ROW_STRIPES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd2, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_MARK, 6'd1, 6'd1}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_STRIPES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd3, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b1, {6'd2, 6'd0, 1'b1, 1'b1}},
		'{ROW_STRIPES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_STRIPES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd2, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_MARK, 6'd1, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b1, {6'd1, 6'd0, 1'b1, 1'b1}},
		'{ROW_STRIPES, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd1, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_CLEAR, 6'd0, 6'd0}, 7'd0, 1'b0, NO_RES},
		'{ROW_WORD, {rbm_pkg::ACT_SOLVE, 6'd0, 6'd0}, 7'd0, 1'b1, {6'd0, 6'd0, 1'b0, 1'b1}}
	};

	int idle_plan [3] = '{36, 56, 0};

	receiver_bipartite_matcher dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.strobe  (strobe),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// One augmenting-path search from stripe root over nodes below n. Each level remembers
	// where its scan stopped, so a level that is resumed carries on past its last node.
	function automatic bit grow_path(input int root, input int n);
		int lvl_stripe [rbm_pkg::MAX_STRIPES+1];
		int lvl_next   [rbm_pkg::MAX_STRIPES+1];
		int lvl_node   [rbm_pkg::MAX_STRIPES+1];
		logic [rbm_pkg::MAX_NODES-1:0] seen;
		int d;
		int s;
		int j;
		bit hit;
		seen = '0;
		d = 0;
		lvl_stripe[0] = root;
		lvl_next[0] = 0;
		while (d >= 0) begin
			s = lvl_stripe[d];
			j = lvl_next[d];
			hit = 1'b0;
			while (j < n && !hit) begin
				if (elig_row[s][j] && !seen[j])
					hit = 1'b1;
				else
					j++;
			end
			if (!hit) begin
				d--;
				continue;
			end
			seen[j] = 1'b1;
			lvl_next[d] = j + 1;
			lvl_node[d] = j;
			if (owner[j] == NODE_FREE) begin
				for (int k = d; k >= 0; k--)
					owner[lvl_node[k]] = rbm_pkg::CNT_W'(lvl_stripe[k]);
				return 1'b1;
			end
			if (d + 1 > rbm_pkg::MAX_STRIPES)
				return 1'b0;
			d++;
			lvl_stripe[d] = int'(owner[j]);
			lvl_next[d] = 0;
		end
		return 1'b0;
	endfunction

	function automatic void apply_word(input rbm_pkg::cmd_t w);
		int n;
		int m;
		int taken_by [rbm_pkg::MAX_STRIPES];
		rbm_pkg::result_t r;
		solve_out = {};
		case (w.action)
			rbm_pkg::ACT_CLEAR: begin
				for (int k = 0; k < rbm_pkg::MAX_STRIPES; k++)
					elig_row[k] = '1;
				for (int k = 0; k < rbm_pkg::MAX_NODES; k++)
					owner[k] = NODE_FREE;
			end
			rbm_pkg::ACT_MARK: begin
				elig_row[w.stripe_index][w.node_id] = 1'b0;
			end
			rbm_pkg::ACT_SOLVE: begin
				n = node_cfg > rbm_pkg::MAX_NODES ? rbm_pkg::MAX_NODES : int'(node_cfg);
				m = stripe_cfg > rbm_pkg::MAX_STRIPES ? rbm_pkg::MAX_STRIPES : int'(stripe_cfg);
				for (int k = 0; k < rbm_pkg::MAX_NODES; k++)
					owner[k] = NODE_FREE;
				for (int s = 0; s < m; s++) begin
					if (!grow_path(s, n)) begin
						r.out_stripe = rbm_pkg::STRIPE_W'(s);
						r.dest_node = '0;
						r.failed = 1'b1;
						r.last = 1'b1;
						solve_out.push_back(r);
						return;
					end
				end
				for (int k = 0; k < rbm_pkg::MAX_NODES; k++)
					if (owner[k] != NODE_FREE)
						taken_by[owner[k][rbm_pkg::STRIPE_W-1:0]] = k;
				for (int s = 0; s < m; s++) begin
					r.out_stripe = rbm_pkg::STRIPE_W'(s);
					r.dest_node = rbm_pkg::NODE_W'(taken_by[s]);
					r.failed = 1'b0;
					r.last = (s + 1 == m);
					solve_out.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	// Presents one word after a random gap and waits for the block to take it.
	task automatic send_word(input rbm_pkg::cmd_t w, input bit typed = 1'b0,
		input rbm_pkg::result_t typed_res = '0);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			cmd = rbm_pkg::cmd_t'(CMD_W'($urandom));
			@(negedge clk);
		end
		start = 1'b1;
		cmd = w;
		do @(posedge clk); while (busy);
		apply_word(w);
		if (typed)
			due_results.push_back(typed_res);
		else
			foreach (solve_out[i])
				due_results.push_back(solve_out[i]);
		if (w.action != ACT_UNUSED)
			words_left--;
	endtask

	// Waits until every expected result is in and the block has gone idle.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [rbm_pkg::CNT_W-1:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {reg_sel, 2'b00};
		pwdata = {25'($urandom), v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == rbm_pkg::REG_NODE_COUNT)
			node_cfg = v;
		else
			stripe_cfg = v;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// A job is an optional register change, usually a clear, a few marks and a solve.
	task automatic random_job(input bit keep_cfg);
		int roll;
		int nc;
		int sc;
		int nmarks;
		logic [rbm_pkg::CNT_W-1:0] nodes;
		logic [rbm_pkg::CNT_W-1:0] stripes;
		rbm_pkg::cmd_t w;
		if (!keep_cfg && $urandom_range(0, 99) < 30) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				nodes = $urandom_range(0, 1) ? 7'd0 : rbm_pkg::CNT_W'($urandom_range(65, 127));
				stripes = rbm_pkg::CNT_W'($urandom_range(0, 3));
			end else if (roll < 12) begin
				nodes = rbm_pkg::CNT_W'($urandom_range(1, 64));
				stripes = rbm_pkg::CNT_W'($urandom_range(65, 127));
			end else begin
				nodes = rbm_pkg::CNT_W'($urandom_range(1, 16));
				stripes = rbm_pkg::CNT_W'($urandom_range(1, nodes < 12 ? nodes + 1 : 12));
			end
			settle();
			write_reg(rbm_pkg::REG_NODE_COUNT, nodes);
			write_reg(rbm_pkg::REG_STRIPE_COUNT, stripes);
		end
		nc = node_cfg > rbm_pkg::MAX_NODES ? rbm_pkg::MAX_NODES :
			(node_cfg == 0 ? 1 : int'(node_cfg));
		sc = stripe_cfg > rbm_pkg::MAX_STRIPES ? rbm_pkg::MAX_STRIPES :
			(stripe_cfg == 0 ? 1 : int'(stripe_cfg));
		if ($urandom_range(0, 99) < 85) begin
			w = rbm_pkg::cmd_t'(CMD_W'($urandom));
			w.action = rbm_pkg::ACT_CLEAR;
			send_word(w);
		end
		nmarks = $urandom_range(0, 2 * sc + 2 < 12 ? 2 * sc + 2 : 12);
		repeat (nmarks) begin
			w = rbm_pkg::cmd_t'(CMD_W'($urandom));
			w.action = rbm_pkg::ACT_MARK;
			// Most marks land inside the active part of the table so that they matter.
			if ($urandom_range(0, 99) < 80) begin
				w.stripe_index = rbm_pkg::STRIPE_W'($urandom_range(0, sc - 1));
				w.node_id = rbm_pkg::NODE_W'($urandom_range(0, nc - 1));
			end
			send_word(w);
		end
		if ($urandom_range(0, 99) < 10) begin
			w = rbm_pkg::cmd_t'(CMD_W'($urandom));
			w.action = ACT_UNUSED;
			send_word(w);
		end
		w = rbm_pkg::cmd_t'(CMD_W'($urandom));
		w.action = rbm_pkg::ACT_SOLVE;
		send_word(w);
	endtask

	task automatic report_mismatch(input string what, input rbm_pkg::result_t want,
		input rbm_pkg::result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected stripe %0d node %0d failed %0b last %0b", what,
				want.out_stripe, want.dest_node, want.failed, want.last);
			$display("    got stripe %0d node %0d failed %0b last %0b",
				got.out_stripe, got.dest_node, got.failed, got.last);
		end
	endtask

	always @(posedge clk) begin : check_results
		rbm_pkg::result_t want;
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with none pending", '0, result);
			end else begin
				want = due_results.pop_front();
				if (result !== want)
					report_mismatch("result mismatch", want, result);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		quiet_cycles = 0;
		idle_pct = 36;
		words_left = 0;
		for (int k = 0; k < rbm_pkg::MAX_STRIPES; k++)
			elig_row[k] = '1;
		for (int k = 0; k < rbm_pkg::MAX_NODES; k++)
			owner[k] = NODE_FREE;
		node_cfg = rbm_pkg::NODE_COUNT_RESET;
		stripe_cfg = rbm_pkg::STRIPE_COUNT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_WORD: send_word(plan[i].w, plan[i].typed, plan[i].res);
				ROW_NODES: begin
					settle();
					write_reg(rbm_pkg::REG_NODE_COUNT, plan[i].value);
				end
				default: begin
					settle();
					write_reg(rbm_pkg::REG_STRIPE_COUNT, plan[i].value);
				end
			endcase
		end

		// Each phase opens on the largest table, then moves on to mostly small ones.
		foreach (idle_plan[p]) begin
			idle_pct = idle_plan[p];
			words_left = RANDOM_WORDS_PER_PHASE;
			settle();
			write_reg(rbm_pkg::REG_NODE_COUNT, 7'd64);
			write_reg(rbm_pkg::REG_STRIPE_COUNT, 7'd64);
			random_job(1'b1);
			while (words_left > 0)
				random_job(1'b0);
		end

		settle();
		if (mismatches == 0 && due_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
src/rbm_pkg.sv
src/rbm_ram.sv
src/receiver_bipartite_matcher.sv
dv/receiver_bipartite_matcher_test.sv
